/* hw/rtl/hvn_pkg.sv */
// Package: shared types and constants for the heightfield normal block.
package hvn_pkg;
   localparam int MAX_SIDE = 64;
   localparam int KIND_W = 2;
   localparam int COORD_W = 6;
   localparam int HGT_W = 16;
   localparam int FLAG_W = 8;
   localparam int NRM_W = 16;
   localparam int ACC_W = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ONE_Q14 = 16384;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD = 2'd0,
      KIND_COMPUTE = 2'd1,
      KIND_READ = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_SIZE = 2'd0,
      CSR_HEIGHT_SCALE = 2'd1,
      CSR_SLOPE_MASK = 2'd2,
      CSR_DIR_SLOPE_MASK = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic signed [HGT_W-1:0] height;
      logic [FLAG_W-1:0] flags;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] vertex_column;
      logic [COORD_W-1:0] vertex_row;
      logic signed [HGT_W-1:0] vertex_height;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic color_red;
      logic color_green;
      logic compute_done;
   } rsp_type;

   // engine state
   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_FRD0, ST_FRD1, ST_FRD2, ST_FRD3, ST_FRD4,
      ST_FSLOPE, ST_FSQ, ST_FROOT, ST_FDIV, ST_FACC, ST_VRD0, ST_VRD1,
      ST_VSQ, ST_VROOT, ST_VDIV, ST_VWR, ST_READ0, ST_READ1, ST_DONE
   } st_type;
endpackage

/* hw/rtl/hvn_stream_if.sv */
// Interface: valid/ready channel carrying one payload.
interface hvn_stream_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/heightfield_vertex_normals.sv */
// Top level: height grid vertex normal generator.
// Load: taken into the queue, then written to the store when the engine pops it.
// Read: popped, addressed, then a registered result beat; no new request while a beat is pending.
// Compute: an accumulator clear over every store entry, then per cell two face normals
//    (a root and three divides each) and a root/divide pass per vertex.
// Reset: synchronous, active high; clears control, queue and CSRs to defaults.
module heightfield_vertex_normals (
   input logic clock,
   input logic reset,
   hvn_stream_if.sink req,
   hvn_stream_if.source rsp,
   input logic csr_we,
   input logic [hvn_pkg::CSR_IDX_W-1:0] csr_idx,
   input logic [hvn_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hvn_pkg::*;
   logic [6:0] grid_size_ff;
   logic [15:0] height_scale_ff;
   logic [7:0] slope_mask_ff, dir_slope_mask_ff;
   logic q_valid, q_pop;
   req_type q_data;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= 7'd64;
         height_scale_ff <= 16'd256;
         slope_mask_ff <= 8'd1;
         dir_slope_mask_ff <= 8'd2;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_GRID_SIZE: grid_size_ff <= csr_wdata[6:0];
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            CSR_SLOPE_MASK: slope_mask_ff <= csr_wdata[7:0];
            CSR_DIR_SLOPE_MASK: dir_slope_mask_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   hvn_front u_front (.clock, .reset, .req(req), .q_valid, .q_data, .q_pop);

   hvn_engine u_engine (
      .clock, .reset, .q_valid, .q_data, .q_pop,
      .grid_size(grid_size_ff), .height_scale(height_scale_ff),
      .slope_mask(slope_mask_ff), .dir_slope_mask(dir_slope_mask_ff),
      .rsp(rsp));
endmodule

/* hw/rtl/hvn_front.sv */
// Front: accepts beats, drops unused kinds, queues the rest.
module hvn_front (
   input logic clock,
   input logic reset,
   hvn_stream_if.sink req,
   output logic q_valid,
   output hvn_pkg::req_type q_data,
   input logic q_pop
);
   import hvn_pkg::*;
   localparam int DEPTH = 2;
   req_type mem_ff [DEPTH];
   logic wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, keep;

   assign req.ready = (cnt_ff != 2'd2);
   assign keep = (req.payload.kind != KIND_NONE);
   assign push = req.valid && req.ready && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ (q_pop && q_valid);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= req.payload;
   end
endmodule

/* hw/rtl/hvn_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
module hvn_sqrt (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [63:0] value,
   output logic busy,
   output logic [31:0] root
);
   logic [63:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [5:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic [63:0] bitv, trial;

   assign busy = busy_ff;
   assign root = res_ff;

   always_comb begin
      bitv = 64'd1 << {step_ff[4:0], 1'b0};
      trial = ({32'd0, res_ff} << (step_ff + 6'd1)) | bitv;
      rem_in = rem_ff;
      res_in = res_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = value;
         res_in = 32'd0;
         step_in = 6'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = res_ff | (32'd1 << step_ff[4:0]);
         end
         if (step_ff == 6'd0) busy_in = 1'b0;
         else step_in = step_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      step_ff <= step_in;
   end
endmodule

/* hw/rtl/hvn_div.sv */
// Restoring divider, one quotient bit per cycle, rounded and clamped to Q1.14.
module hvn_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [47:0] num,
   input logic [31:0] den,
   output logic busy,
   output logic [14:0] quot
);
   logic [47:0] q_ff, q_in;
   logic [48:0] r_ff, r_in, sh;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;

   assign busy = busy_ff;
   assign quot = (q_ff > 48'd16384) ? 15'd16384 : q_ff[14:0];

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      sh = {r_ff[47:0], q_ff[47]};
      if (start) begin
         q_in = num + {17'd0, den[31:1]};
         r_in = 49'd0;
         cnt_in = 6'd47;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {17'd0, den}) begin
            r_in = sh - {17'd0, den};
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[46:0], 1'b0};
         end
         if (cnt_ff == 6'd0) busy_in = 1'b0;
         else cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
   end
endmodule

/* hw/rtl/hvn_engine.sv */
// Back end: stores, face and vertex normal passes, reads.
module hvn_engine (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input hvn_pkg::req_type q_data,
   output logic q_pop,
   input logic [6:0] grid_size,
   input logic [15:0] height_scale,
   input logic [7:0] slope_mask,
   input logic [7:0] dir_slope_mask,
   hvn_stream_if.source rsp
);
   import hvn_pkg::*;
   localparam int SW = $clog2(MAX_SIDE);
   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW = 2 * SW;

   logic [HGT_W-1:0] hmem [CELLS];
   logic [FLAG_W-1:0] fmem [CELLS];
   logic [3*ACC_W-1:0] amem [CELLS];
   logic [3*NRM_W-1:0] nmem [CELLS];

   st_type st_ff, st_in;
   req_type cur_ff, cur_in;
   logic [SW:0] c_ff, c_in, r_ff, r_in;
   logic [SW:0] n_ff, n_in;
   logic tri_ff, tri_in;
   logic [1:0] k_ff, k_in;
   logic [AW:0] clr_ff, clr_in;
   logic signed [HGT_W-1:0] h_ff [4];
   logic signed [HGT_W-1:0] hrd_ff;
   logic [FLAG_W-1:0] frd_ff;
   logic [3*ACC_W-1:0] ard_ff;
   logic [3*NRM_W-1:0] nrd_ff;
   logic signed [26:0] v_ff [3];
   logic signed [26:0] v_in [3];
   logic [63:0] l2_ff, l2_in;
   logic signed [ACC_W-1:0] f_ff [3];
   logic signed [ACC_W-1:0] f_in [3];
   logic [1:0] comp_ff, comp_in;
   logic rv_ff, rv_in;
   rsp_type rd_ff, rd_in;
   logic vmode_ff, vmode_in;

   logic [AW-1:0] raddr, waddr;
   logic hwe, awe, nwe, aclr;
   logic [3*ACC_W-1:0] awd;
   logic [3*NRM_W-1:0] nwd;
   logic sq_start, dv_start, sq_busy, dv_busy;
   logic [31:0] root;
   logic [14:0] quot;
   logic [47:0] dnum;
   logic [1:0] mi;
   logic [26:0] mag;
   logic signed [33:0] prod;
   logic signed [26:0] sl;
   logic signed [16:0] dif;
   logic [53:0] msq;
   logic [SW-1:0] ca, ra;

   hvn_sqrt u_sqrt (.clock, .reset, .start(sq_start), .value(l2_in),
      .busy(sq_busy), .root(root));
   hvn_div u_div (.clock, .reset, .start(dv_start), .num(dnum), .den(root),
      .busy(dv_busy), .quot(quot));

   assign rsp.valid = rv_ff;
   assign rsp.payload = rd_ff;

   function automatic logic [AW-1:0] addr(input logic [SW:0] c, input logic [SW:0] r);
      addr = {c[SW-1:0], r[SW-1:0]};
   endfunction

   always_comb begin
      // divide phases launch the next component, square phases use the current one
      mi = (st_ff == ST_FDIV || st_ff == ST_VDIV) ? comp_ff + 2'd1 : comp_ff;
      mag = v_ff[mi][26] ? 27'(-v_ff[mi]) : v_ff[mi];
      dnum = vmode_ff ? ({21'd0, mag} << 24) : ({21'd0, mag} << 20);
      msq = 54'(mag) * 54'(mag);
      dif = (k_ff == 2'd0) ? 17'(h_ff[1]) - 17'(h_ff[0]) :
            (k_ff == 2'd1) ? 17'(h_ff[2]) - 17'(h_ff[0]) :
            (k_ff == 2'd2) ? 17'(h_ff[2]) - 17'(h_ff[3]) :
                             17'(h_ff[1]) - 17'(h_ff[3]);
      prod = 34'(dif) * $signed({18'd0, height_scale});
      sl = 27'(prod >>> 8);
      ca = cur_ff.column[SW-1:0];
      ra = cur_ff.row[SW-1:0];
   end

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; c_in = c_ff; r_in = r_ff; n_in = n_ff;
      tri_in = tri_ff; k_in = k_ff; clr_in = clr_ff; l2_in = l2_ff;
      comp_in = comp_ff; rv_in = rv_ff; rd_in = rd_ff; vmode_in = vmode_ff;
      v_in = v_ff; f_in = f_ff;
      q_pop = 1'b0; raddr = '0; waddr = '0; hwe = 1'b0; awe = 1'b0; nwe = 1'b0;
      aclr = 1'b0; awd = '0; nwd = '0; sq_start = 1'b0; dv_start = 1'b0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_valid && !rv_ff) begin
               q_pop = 1'b1;
               cur_in = q_data;
               case (q_data.kind)
                  KIND_LOAD: begin
                     hwe = (32'(q_data.column) < MAX_SIDE) && (32'(q_data.row) < MAX_SIDE);
                     waddr = {q_data.column[SW-1:0], q_data.row[SW-1:0]};
                  end
                  KIND_COMPUTE: begin
                     n_in = (grid_size > 7'(MAX_SIDE)) ? (SW+1)'(MAX_SIDE) : (SW+1)'(grid_size);
                     clr_in = '0;
                     st_in = ST_CLEAR;
                  end
                  default: st_in = ST_READ0;
               endcase
            end
         end
         ST_CLEAR: begin
            aclr = 1'b1;
            waddr = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(CELLS - 1)) begin
               c_in = '0; r_in = '0; tri_in = 1'b0;
               st_in = (n_ff < 2) ? (n_ff == 0 ? ST_DONE : ST_VRD0) : ST_FRD0;
            end
         end
         ST_FRD0: begin raddr = addr(c_ff, r_ff); st_in = ST_FRD1; end
         ST_FRD1: begin raddr = addr(c_ff + 1'b1, r_ff); st_in = ST_FRD2; end
         ST_FRD2: begin raddr = addr(c_ff, r_ff + 1'b1); st_in = ST_FRD3; end
         ST_FRD3: begin raddr = addr(c_ff + 1'b1, r_ff + 1'b1); st_in = ST_FRD4; end
         ST_FRD4: begin k_in = tri_ff ? 2'd2 : 2'd0; st_in = ST_FSLOPE; end
         ST_FSLOPE: begin
            if (k_ff == 2'd0 || k_ff == 2'd2) begin
               v_in[0] = tri_ff ? sl : 27'(-sl);
               k_in = k_ff + 1'b1;
            end else begin
               v_in[1] = tri_ff ? sl : 27'(-sl);
               v_in[2] = 27'sd256;
               comp_in = 2'd0; l2_in = '0; vmode_in = 1'b0;
               st_in = ST_FSQ;
            end
         end
         ST_FSQ, ST_VSQ: begin
            l2_in = l2_ff + 64'(msq);
            if (comp_ff == 2'd2) begin
               comp_in = 2'd0;
               st_in = (st_ff == ST_FSQ) ? ST_FROOT : ST_VROOT;
            end else comp_in = comp_ff + 1'b1;
         end
         ST_FROOT, ST_VROOT: begin
            l2_in = (st_ff == ST_FROOT) ? (l2_ff << 12) : (l2_ff << 20);
            if (l2_ff == 0 && st_ff == ST_VROOT) begin
               f_in[0] = '0; f_in[1] = '0; f_in[2] = '0;
               st_in = ST_VWR;
            end else begin
               sq_start = 1'b1;
               st_in = (st_ff == ST_FROOT) ? ST_FDIV : ST_VDIV;
               comp_in = 2'd3;
            end
         end
         ST_FDIV, ST_VDIV: begin
            if (!sq_busy && !dv_busy && !sq_start) begin
               if (comp_ff != 2'd3)
                  f_in[comp_ff] = v_ff[comp_ff][26] ? -ACC_W'(quot) : ACC_W'(quot);
               if (comp_ff == 2'd2) begin
                  comp_in = 2'd0;
                  k_in = 2'd0;
                  st_in = (st_ff == ST_FDIV) ? ST_FACC : ST_VWR;
               end else begin
                  comp_in = comp_ff + 1'b1;
                  dv_start = 1'b1;
               end
            end
         end
         ST_FACC: begin
            // read-modify-write of the three corners in turn: read on even k, written back on odd k
            case (comp_ff)
               2'd0: raddr = tri_ff ? addr(c_ff, r_ff + 1'b1) : addr(c_ff, r_ff);
               2'd1: raddr = tri_ff ? addr(c_ff + 1'b1, r_ff) : addr(c_ff, r_ff + 1'b1);
               default: raddr = tri_ff ? addr(c_ff + 1'b1, r_ff + 1'b1)
                                       : addr(c_ff + 1'b1, r_ff);
            endcase
            k_in = k_ff + 1'b1;
            if (k_ff[0]) begin
               awe = 1'b1;
               waddr = raddr;
               awd = {ard_ff[59:40] + f_ff[0], ard_ff[39:20] + f_ff[1],
                      ard_ff[19:0] + f_ff[2]};
               if (comp_ff == 2'd2) begin
                  comp_in = 2'd0;
                  if (!tri_ff) begin
                     tri_in = 1'b1; st_in = ST_FRD4;
                  end else begin
                     tri_in = 1'b0;
                     st_in = ST_FRD0;
                     if (r_ff + 2 >= n_ff) begin
                        r_in = '0;
                        if (c_ff + 2 >= n_ff) begin
                           c_in = '0; st_in = ST_VRD0;
                        end else c_in = c_ff + 1'b1;
                     end else r_in = r_ff + 1'b1;
                  end
               end else comp_in = comp_ff + 1'b1;
            end
         end
         ST_VRD0: begin raddr = addr(c_ff, r_ff); st_in = ST_VRD1; end
         ST_VRD1: begin
            v_in[0] = (c_ff == 0 || c_ff == n_ff - 1) ? 27'sd0 :
                      27'($signed(ard_ff[59:40]));
            v_in[1] = (r_ff == 0 || r_ff == n_ff - 1) ? 27'sd0 :
                      27'($signed(ard_ff[39:20]));
            v_in[2] = 27'($signed(ard_ff[19:0]));
            comp_in = 2'd0; l2_in = '0; vmode_in = 1'b1;
            st_in = ST_VSQ;
         end
         ST_VWR: begin
            nwe = 1'b1;
            waddr = addr(c_ff, r_ff);
            nwd = {f_ff[0][15:0], f_ff[1][15:0], f_ff[2][15:0]};
            st_in = ST_VRD0;
            if (r_ff == n_ff - 1) begin
               r_in = '0;
               if (c_ff == n_ff - 1) st_in = ST_DONE;
               else c_in = c_ff + 1'b1;
            end else r_in = r_ff + 1'b1;
         end
         ST_DONE: begin
            if (!rv_ff) begin
               rd_in = '0; rd_in.compute_done = 1'b1; rv_in = 1'b1; st_in = ST_IDLE;
            end
         end
         ST_READ0: begin raddr = {ca, ra}; st_in = ST_READ1; end
         ST_READ1: begin
            rd_in = '0;
            rd_in.vertex_column = cur_ff.column;
            rd_in.vertex_row = cur_ff.row;
            if ((32'(cur_ff.column) < MAX_SIDE) && (32'(cur_ff.row) < MAX_SIDE)) begin
               rd_in.vertex_height = hrd_ff;
               rd_in.normal_x = nrd_ff[47:32];
               rd_in.normal_y = nrd_ff[31:16];
               rd_in.normal_z = nrd_ff[15:0];
               rd_in.color_red = |(frd_ff & (slope_mask | dir_slope_mask));
               rd_in.color_green = ~|(frd_ff & slope_mask);
            end else rd_in.color_green = 1'b1;
            rv_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      cur_ff <= cur_in; c_ff <= c_in; r_ff <= r_in; n_ff <= n_in;
      tri_ff <= tri_in; k_ff <= k_in; clr_ff <= clr_in; l2_ff <= l2_in;
      comp_ff <= comp_in; rd_ff <= rd_in; vmode_ff <= vmode_in;
      v_ff <= v_in; f_ff <= f_in;
      // height shift line for the four cell corners, loaded once per cell
      if (st_ff == ST_FRD1 || st_ff == ST_FRD2 || st_ff == ST_FRD3 ||
          (st_ff == ST_FRD4 && !tri_ff)) begin
         h_ff[0] <= h_ff[1]; h_ff[1] <= h_ff[2]; h_ff[2] <= h_ff[3];
         h_ff[3] <= hrd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (hwe) begin
         hmem[waddr] <= q_data.height;
         fmem[waddr] <= q_data.flags;
      end
      hrd_ff <= hmem[raddr];
      frd_ff <= fmem[raddr];
   end

   always_ff @(posedge clock) begin
      if (aclr) amem[waddr] <= '0;
      else if (awe) amem[waddr] <= awd;
      ard_ff <= amem[raddr];
   end

   always_ff @(posedge clock) begin
      if (nwe) nmem[waddr] <= nwd;
      nrd_ff <= nmem[raddr];
   end
endmodule

/* hw/rtl/hvn_checker.sv */
// Checker: port-level properties of the normal generator, bound to the top.
module hvn_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_done,
   input logic [15:0] rsp_nz,
   input logic rsp_green
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done |-> rsp_nz == 16'd0 && rsp_green == 1'b0)
      else $error("compute beat not clean");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp valid after reset");
endmodule

bind heightfield_vertex_normals hvn_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_done(rsp.payload.compute_done), .rsp_nz(rsp.payload.normal_z),
   .rsp_green(rsp.payload.color_green));
